### design/prefix_varint_stream_decoder_assert.svh
// Assertion macros used by the decoder RTL.
`ifndef PREFIX_VARINT_STREAM_DECODER_ASSERT_SVH
`define PREFIX_VARINT_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define PVSD_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, held off during reset.
`define PVSD_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/pvsd_pkg.sv
package pvsd_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned LEFT_W  = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'hF;

  // Leading byte masks and match codes
  localparam logic [7:0] MASK_1  = 8'h80;
  localparam logic [7:0] CODE_7  = 8'h00;
  localparam logic [7:0] MASK_2  = 8'hC0;
  localparam logic [7:0] CODE_14 = 8'h80;
  localparam logic [7:0] MASK_3  = 8'hE0;
  localparam logic [7:0] CODE_21 = 8'hC0;
  localparam logic [7:0] MASK_4  = 8'hF0;
  localparam logic [7:0] CODE_28 = 8'hE0;
  localparam logic [7:0] MASK_6  = 8'hFC;
  localparam logic [7:0] CODE_32 = 8'hF0;
  localparam logic [7:0] CODE_64 = 8'hF4;
  localparam logic [7:0] CODE_NEG = 8'hF8;

  // Payload masks of the leading byte
  localparam logic [7:0] PAY_7  = 8'h7F;
  localparam logic [7:0] PAY_14 = 8'h3F;
  localparam logic [7:0] PAY_21 = 8'h1F;
  localparam logic [7:0] PAY_28 = 8'h0F;
  localparam logic [7:0] PAY_SN = 8'h03;

  // Continuation byte counts
  localparam logic [LEFT_W-1:0] LEFT_14 = 4'd1;
  localparam logic [LEFT_W-1:0] LEFT_21 = 4'd2;
  localparam logic [LEFT_W-1:0] LEFT_28 = 4'd3;
  localparam logic [LEFT_W-1:0] LEFT_32 = 4'd4;
  localparam logic [LEFT_W-1:0] LEFT_64 = 4'd8;

  typedef struct packed {
    logic [LEFT_W-1:0]  bytes_left;
    logic [VALUE_W-1:0] acc;
    logic               neg;
    logic [COUNT_W-1:0] count;
  } pvsd_state_t;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } pvsd_result_t;

endpackage

### design/prefix_varint_stream_decoder.sv
// Prefix-coded varint stream decoder. Takes one encoded byte per cycle on the
// in_ channel while in_ready is high and delivers each decoded 64-bit signed
// value with its byte count on the out_ channel from a registered result word.
// Bytes are accepted while in_ready is high; a result register plus a one-word
// skid register let the input keep flowing while a result waits, so in_ready
// only drops when both hold words the consumer has not taken. Negation prefix
// bytes and continuation bytes other than the last produce no result.
`include "prefix_varint_stream_decoder_assert.svh"

module prefix_varint_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [63:0] out_value,
  output logic [3:0]  out_byte_count
);

  pvsd_pkg::pvsd_state_t  st_r, st_nxt;
  pvsd_pkg::pvsd_result_t res;

  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_value_r, out_value_nxt;
  logic [3:0]  out_count_r, out_count_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic [63:0] skid_value_r, skid_value_nxt;
  logic [3:0]  skid_count_r, skid_count_nxt;

  logic in_fire, out_fire, res_fire;

  assign in_ready = ~skid_valid_r;
  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid_r & out_ready;
  assign res_fire = in_fire & res.valid;

  pvsd_decode u_decode (
    .cur       (st_r),
    .data_byte (in_data_byte),
    .nxt       (st_nxt),
    .res       (res)
  );

  // result register and skid word
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    skid_valid_nxt = skid_valid_r;
    skid_value_nxt = skid_value_r;
    skid_count_nxt = skid_count_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_value_nxt  = skid_value_r;
        out_count_nxt  = skid_count_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_fire) begin
      if (!out_valid_r || out_fire) begin
        out_valid_nxt = 1'b1;
        out_value_nxt = res.value;
        out_count_nxt = res.count;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_value_nxt = res.value;
        skid_count_nxt = res.count;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r <= st_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload words
  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    skid_value_r <= skid_value_nxt;
    skid_count_r <= skid_count_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_byte_count = out_count_r;

  // checks
  `PVSD_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `PVSD_ASSERT_NOW(a_left_range, clk, rst_n, 1'b1, st_r.bytes_left <= pvsd_pkg::LEFT_64)
  `PVSD_ASSERT_NEXT(a_short_form_result, clk, rst_n,
    in_fire && (st_r.bytes_left == 4'd0) && !in_data_byte[7], out_valid_r)

endmodule

### design/pvsd_decode.sv
// Next-state and result logic for one stream byte.
module pvsd_decode (
  input  pvsd_pkg::pvsd_state_t  cur,
  input  logic [7:0]             data_byte,
  output pvsd_pkg::pvsd_state_t  nxt,
  output pvsd_pkg::pvsd_result_t res
);

  logic [pvsd_pkg::COUNT_W-1:0] cnt_inc;
  logic [pvsd_pkg::VALUE_W-1:0] acc_new;
  logic                         done;

  // saturating byte count
  assign cnt_inc = (cur.count == pvsd_pkg::COUNT_MAX) ? cur.count
                                                       : cur.count + 4'd1;

  // classify the byte and build the partial state
  always_comb begin
    nxt        = cur;
    nxt.count  = cnt_inc;
    acc_new    = cur.acc;
    done       = 1'b0;
    if (cur.bytes_left != '0) begin
      acc_new        = {cur.acc[pvsd_pkg::VALUE_W-9:0], data_byte};
      nxt.bytes_left = cur.bytes_left - 4'd1;
      done           = (cur.bytes_left == 4'd1);
    end else if ((data_byte & pvsd_pkg::MASK_1) == pvsd_pkg::CODE_7) begin
      acc_new = {56'd0, data_byte & pvsd_pkg::PAY_7};
      done    = 1'b1;
    end else if ((data_byte & pvsd_pkg::MASK_2) == pvsd_pkg::CODE_14) begin
      acc_new        = {56'd0, data_byte & pvsd_pkg::PAY_14};
      nxt.bytes_left = pvsd_pkg::LEFT_14;
    end else if ((data_byte & pvsd_pkg::MASK_3) == pvsd_pkg::CODE_21) begin
      acc_new        = {56'd0, data_byte & pvsd_pkg::PAY_21};
      nxt.bytes_left = pvsd_pkg::LEFT_21;
    end else if ((data_byte & pvsd_pkg::MASK_4) == pvsd_pkg::CODE_28) begin
      acc_new        = {56'd0, data_byte & pvsd_pkg::PAY_28};
      nxt.bytes_left = pvsd_pkg::LEFT_28;
    end else if ((data_byte & pvsd_pkg::MASK_6) == pvsd_pkg::CODE_32) begin
      acc_new        = '0;
      nxt.bytes_left = pvsd_pkg::LEFT_32;
    end else if ((data_byte & pvsd_pkg::MASK_6) == pvsd_pkg::CODE_64) begin
      acc_new        = '0;
      nxt.bytes_left = pvsd_pkg::LEFT_64;
    end else if ((data_byte & pvsd_pkg::MASK_6) == pvsd_pkg::CODE_NEG) begin
      nxt.neg = ~cur.neg;
    end else begin
      // small negative form: ~(0..3)
      acc_new = ~{56'd0, data_byte & pvsd_pkg::PAY_SN};
      done    = 1'b1;
    end
    nxt.acc = acc_new;

    // a finished value returns the state to its idle values
    if (done) begin
      nxt.bytes_left = '0;
      nxt.acc        = '0;
      nxt.neg        = 1'b0;
      nxt.count      = '0;
    end
  end

  // result word
  always_comb begin
    res.valid = done;
    res.value = cur.neg ? ~acc_new : acc_new;
    res.count = cnt_inc;
  end

endmodule
